[rtl/sorted_table_interpolator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table interpolator
// Shared check forms; each use names its own label and message.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define SORTED_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define STI_CHECK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define STI_CHECK_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

[rtl/sti_pkg.sv]
// ----------------------------------------------------------------------------
// sti_pkg
// Types and constants shared by the interpolator front, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int EXT_W       = VALUE_WIDTH + 1;
   localparam int PROD_W      = 2 * EXT_W;
   localparam int STEP_W      = $clog2(EXT_W);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_INTERP  = 2'd1,
      OP_NEAREST = 2'd2
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic [IDX_W-1:0]               slot;
      logic signed [VALUE_WIDTH-1:0]  x;
      logic signed [VALUE_WIDTH-1:0]  y;
      logic signed [VALUE_WIDTH-1:0]  target;
      logic [CNT_W-1:0]               cnt;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BND0,
      S_BND1,
      S_BNDCHK,
      S_SRD,
      S_SCMP,
      S_SEL,
      S_YCAP,
      S_NBL,
      S_NBR,
      S_NBCAP,
      S_EVAL,
      S_MUL,
      S_DIV,
      S_FIN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/sti_ram.sv]
// ----------------------------------------------------------------------------
// sti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[rtl/sti_front.sv]
// ----------------------------------------------------------------------------
// sti_front
// Accepts request transactions, drops the unused mode, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_interpolator_unit_macros.svh"

module sti_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [sti_pkg::IDX_W-1:0]            req_slot,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_point_x,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_point_y,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_target,
   input  wire logic [sti_pkg::CNT_W-1:0]            req_search_count,
   output logic                                      q_valid,
   output sti_pkg::item_type                         q_item,
   input  wire logic                                 q_pop
);
   import sti_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [QC_W-1:0]    count_ff;
   logic               accept;
   logic               push;
   logic               known;
   item_type           new_item;

   assign req_stall = (count_ff == QC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Classify: only defined modes enter the queue
   always_comb begin
      case (req_mode)
         OP_WRITE, OP_INTERP, OP_NEAREST: known = 1'b1;
         default:                         known = 1'b0;
      endcase
   end

   assign push     = accept && known;
   assign new_item = '{op:     op_type'(req_mode),
                       slot:   req_slot,
                       x:      req_point_x,
                       y:      req_point_y,
                       target: req_target,
                       cnt:    req_search_count};

   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

   // Store pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({push, q_pop})
            2'b10:   count_ff <= count_ff + QC_W'(1);
            2'b01:   count_ff <= count_ff - QC_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   `STI_CHECK(a_count_bound, count_ff <= QC_W'(QUEUE_DEPTH), "queue count overflow")
   `STI_CHECK(a_pop_nonempty, !q_pop || count_ff != '0, "pop from empty queue")
   `STI_CHECK_NEXT(a_push_counts, push && !q_pop, count_ff != '0, "push lost")

endmodule

`default_nettype wire

[rtl/sti_back.sv]
// ----------------------------------------------------------------------------
// sti_back
// Executes queued transactions: table writes, bounded binary search, and a
// serial multiply followed by a serial divide for the interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_interpolator_unit_macros.svh"

module sti_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [sti_pkg::CNT_W-1:0]            csr_wr_data,
   input  wire logic                                 q_valid,
   input  wire sti_pkg::item_type                    q_item,
   output logic                                      q_pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_ok,
   output logic signed [sti_pkg::VALUE_WIDTH-1:0]    rsp_sample_value,
   output logic [sti_pkg::IDX_W-1:0]                 rsp_nearest_index
);
   import sti_pkg::*;

   state_type                       state_ff;
   state_type                       state_in;
   logic [CNT_W-1:0]                piu_ff;
   op_type                          op_ff;
   logic signed [VALUE_WIDTH-1:0]   t_ff;
   logic [CNT_W-1:0]                n_ff;
   logic [CNT_W-1:0]                first_ff;
   logic [CNT_W-1:0]                len_ff;
   logic                            fail_ff;
   logic signed [VALUE_WIDTH-1:0]   xl_ff;
   logic signed [VALUE_WIDTH-1:0]   yl_ff;
   logic signed [VALUE_WIDTH-1:0]   xr_ff;
   logic signed [VALUE_WIDTH-1:0]   yr_ff;
   logic [EXT_W-1:0]                span_ff;
   logic [EXT_W-1:0]                mag_ff;
   logic [EXT_W-1:0]                m_ff;
   logic                            neg_ff;
   logic [PROD_W-1:0]               acc_ff;
   logic [EXT_W-1:0]                rem_ff;
   logic [EXT_W-1:0]                low_ff;
   logic [STEP_W-1:0]               step_ff;
   logic                            res_ok_ff;
   logic signed [VALUE_WIDTH-1:0]   res_val_ff;
   logic [IDX_W-1:0]                res_idx_ff;
   logic                            rsp_valid_ff;

   logic                            ram_we;
   logic [IDX_W-1:0]                rd_addr;
   logic [VALUE_WIDTH-1:0]          x_rdata;
   logic [VALUE_WIDTH-1:0]          y_rdata;
   logic signed [VALUE_WIDTH-1:0]   x_rd;
   logic [CNT_W-1:0]                n_use;
   logic [CNT_W-1:0]                n_item;
   logic [CNT_W-1:0]                half;
   logic [CNT_W-1:0]                mid;
   logic [CNT_W-1:0]                r_m1;
   logic [CNT_W-1:0]                n_m1;
   logic signed [EXT_W-1:0]         span_s;
   logic signed [EXT_W-1:0]         m_raw;
   logic signed [EXT_W-1:0]         diff_s;
   logic signed [EXT_W-1:0]         dl_s;
   logic signed [EXT_W-1:0]         dr_s;
   logic [EXT_W-1:0]                dl_abs;
   logic [EXT_W-1:0]                dr_abs;
   logic [EXT_W-1:0]                m_clamp;
   logic [PROD_W-1:0]               acc_next;
   logic [EXT_W:0]                  trial;
   logic                            trial_ge;
   logic                            out_free;
   logic                            last_step;

   // Table memories share one write and one read address
   sti_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_x_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (q_item.slot),
      .wdata (q_item.x),
      .raddr (rd_addr),
      .rdata (x_rdata)
   );

   sti_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_y_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (q_item.slot),
      .wdata (q_item.y),
      .raddr (rd_addr),
      .rdata (y_rdata)
   );

   assign x_rd = $signed(x_rdata);

   // Clamp point counts to the table depth and the search count
   assign n_use  = (piu_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : piu_ff;
   assign n_item = (q_item.op == OP_NEAREST && q_item.cnt < n_use) ? q_item.cnt : n_use;

   // Search and neighbor addressing
   assign half = len_ff >> 1;
   assign mid  = first_ff + half;
   assign r_m1 = first_ff - CNT_W'(1);
   assign n_m1 = n_ff - CNT_W'(1);

   // Segment arithmetic on sign-extended operands
   assign span_s  = $signed({xr_ff[VALUE_WIDTH-1], xr_ff}) - $signed({xl_ff[VALUE_WIDTH-1], xl_ff});
   assign m_raw   = $signed({t_ff[VALUE_WIDTH-1], t_ff}) - $signed({xl_ff[VALUE_WIDTH-1], xl_ff});
   assign diff_s  = $signed({yr_ff[VALUE_WIDTH-1], yr_ff}) - $signed({yl_ff[VALUE_WIDTH-1], yl_ff});
   assign dl_s    = $signed({xl_ff[VALUE_WIDTH-1], xl_ff}) - $signed({t_ff[VALUE_WIDTH-1], t_ff});
   assign dr_s    = $signed({xr_ff[VALUE_WIDTH-1], xr_ff}) - $signed({t_ff[VALUE_WIDTH-1], t_ff});
   assign dl_abs  = dl_s[EXT_W-1] ? EXT_W'(-dl_s) : EXT_W'(dl_s);
   assign dr_abs  = dr_s[EXT_W-1] ? EXT_W'(-dr_s) : EXT_W'(dr_s);
   assign m_clamp = m_raw[EXT_W-1] ? '0 :
                    (m_raw > span_s) ? EXT_W'(span_s) : EXT_W'(m_raw);

   // One multiply step and one restoring divide step
   assign acc_next = {acc_ff[PROD_W-2:0], 1'b0} +
                     (m_ff[EXT_W-1] ? {{EXT_W{1'b0}}, mag_ff} : '0);
   assign trial    = {rem_ff, low_ff[EXT_W-1]};
   assign trial_ge = (trial >= {1'b0, span_ff});
   assign last_step = (step_ff == STEP_W'(EXT_W - 1));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_INTERP:  state_in = (n_item == '0) ? S_DONE : S_BND0;
                  OP_NEAREST: state_in = (n_item < CNT_W'(2)) ? S_DONE : S_SRD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_BND0:   state_in = S_BND1;
         S_BND1:   state_in = S_BNDCHK;
         S_BNDCHK: state_in = (fail_ff || t_ff > x_rd) ? S_DONE : S_SRD;
         S_SRD:    state_in = (len_ff == '0) ? S_SEL : S_SCMP;
         S_SCMP:   state_in = S_SRD;
         S_SEL: begin
            if (first_ff == '0 || first_ff == n_ff) begin
               state_in = (op_ff == OP_INTERP) ? S_YCAP : S_DONE;
            end else begin
               state_in = S_NBL;
            end
         end
         S_YCAP:   state_in = S_DONE;
         S_NBL:    state_in = S_NBR;
         S_NBR:    state_in = S_NBCAP;
         S_NBCAP:  state_in = S_EVAL;
         S_EVAL: begin
            if (op_ff == OP_INTERP && !span_s[EXT_W-1] && span_s != '0) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL:    state_in = last_step ? S_DIV : S_MUL;
         S_DIV:    state_in = last_step ? S_FIN : S_DIV;
         S_FIN:    state_in = S_DONE;
         S_DONE:   state_in = out_free ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs: queue pop, table write and read address
   always_comb begin
      q_pop   = 1'b0;
      ram_we  = 1'b0;
      rd_addr = '0;
      case (state_ff)
         S_IDLE: begin
            q_pop  = q_valid;
            ram_we = q_valid && (q_item.op == OP_WRITE);
         end
         S_BND1:  rd_addr = n_m1[IDX_W-1:0];
         S_SRD:   rd_addr = mid[IDX_W-1:0];
         S_SEL:   rd_addr = (first_ff == n_ff) ? n_m1[IDX_W-1:0] : '0;
         S_NBL:   rd_addr = r_m1[IDX_W-1:0];
         S_NBR:   rd_addr = first_ff[IDX_W-1:0];
         default: rd_addr = '0;
      endcase
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         piu_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            piu_ff <= csr_wr_data;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            op_ff      <= q_item.op;
            t_ff       <= q_item.target;
            n_ff       <= n_item;
            first_ff   <= '0;
            len_ff     <= n_item;
            fail_ff    <= 1'b0;
            res_ok_ff  <= (q_item.op == OP_NEAREST);
            res_val_ff <= '0;
            res_idx_ff <= '0;
         end
         S_BND1: fail_ff <= (t_ff < x_rd);
         S_SCMP: begin
            if (x_rd < t_ff) begin
               first_ff <= mid + CNT_W'(1);
               len_ff   <= len_ff - half - CNT_W'(1);
            end else begin
               len_ff   <= half;
            end
         end
         S_SEL: begin
            if (op_ff == OP_NEAREST && first_ff == n_ff) begin
               res_idx_ff <= n_m1[IDX_W-1:0];
            end
         end
         S_BNDCHK: begin
            if (!(fail_ff || t_ff > x_rd)) begin
               res_ok_ff <= 1'b1;
            end
         end
         S_YCAP: res_val_ff <= $signed(y_rdata);
         S_NBR: begin
            xl_ff <= x_rd;
            yl_ff <= $signed(y_rdata);
         end
         S_NBCAP: begin
            xr_ff <= x_rd;
            yr_ff <= $signed(y_rdata);
         end
         S_EVAL: begin
            if (op_ff == OP_NEAREST) begin
               res_idx_ff <= (dl_abs <= dr_abs) ? r_m1[IDX_W-1:0] : first_ff[IDX_W-1:0];
            end else begin
               res_val_ff <= yr_ff;
            end
            span_ff <= EXT_W'(span_s);
            mag_ff  <= diff_s[EXT_W-1] ? EXT_W'(-diff_s) : EXT_W'(diff_s);
            neg_ff  <= diff_s[EXT_W-1];
            m_ff    <= m_clamp;
            acc_ff  <= '0;
            step_ff <= '0;
         end
         S_MUL: begin
            acc_ff  <= acc_next;
            m_ff    <= {m_ff[EXT_W-2:0], 1'b0};
            step_ff <= last_step ? '0 : step_ff + STEP_W'(1);
            if (last_step) begin
               rem_ff <= acc_next[PROD_W-1:EXT_W];
               low_ff <= acc_next[EXT_W-1:0];
            end
         end
         S_DIV: begin
            rem_ff  <= trial_ge ? EXT_W'(trial - {1'b0, span_ff}) : trial[EXT_W-1:0];
            low_ff  <= {low_ff[EXT_W-2:0], trial_ge};
            step_ff <= step_ff + STEP_W'(1);
         end
         S_FIN: begin
            res_val_ff <= neg_ff ? yl_ff - $signed(low_ff[VALUE_WIDTH-1:0])
                                 : yl_ff + $signed(low_ff[VALUE_WIDTH-1:0]);
         end
         default: begin
         end
      endcase
   end

   // Load the output register when it frees up
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_ok            <= res_ok_ff;
         rsp_sample_value  <= res_ok_ff ? res_val_ff : '0;
         rsp_nearest_index <= res_idx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `STI_CHECK(a_pop_idle, !q_pop || state_ff == S_IDLE, "pop outside idle")
   `STI_CHECK(a_div_span, state_ff != S_DIV || span_ff != '0, "divide by zero span")
   `STI_CHECK_NEXT(a_done_loads, state_ff == S_DONE && out_free, rsp_valid_ff,
                   "result not presented")

endmodule

`default_nettype wire

[rtl/sorted_table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_interpolator_unit
// Piecewise linear interpolation and nearest-breakpoint lookup over a table.
// ----------------------------------------------------------------------------
// Request channel (req_*): valid/stall; mode 0 writes slot with point_x and
// point_y and gives no response, mode 1 interpolates at target, mode 2 finds
// the breakpoint nearest target over search_count entries; mode 3 is dropped.
// Response channel (rsp_*): one transaction per mode 1 or 2 request, in order.
// csr_wr_en/csr_wr_data set the number of breakpoints in use; write it only
// while the unit is idle.
// A two-entry queue parts the request side from the executing sequencer, so
// requests keep flowing while a response waits on a stalled receiver; a held
// response blocks the sequencer until the receiver takes it.
// A write completes in the idle state; a nearest query runs a binary search
// and a neighbour compare; an interpolation adds a bounds check, and between
// neighbours the 33-step serial multiply and the 33-step serial divide. Table reads come
// one per cycle from a single registered read port per table.
// Reset clears the point count, the queue and the response valid; table
// contents are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_interpolator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [sti_pkg::IDX_W-1:0]            req_slot,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_point_x,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_point_y,
   input  wire logic signed [sti_pkg::VALUE_WIDTH-1:0] req_target,
   input  wire logic [sti_pkg::CNT_W-1:0]            req_search_count,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_ok,
   output logic signed [sti_pkg::VALUE_WIDTH-1:0]    rsp_sample_value,
   output logic [sti_pkg::IDX_W-1:0]                 rsp_nearest_index,
   input  wire logic                                 csr_wr_en,
   input  wire logic [sti_pkg::CNT_W-1:0]            csr_wr_data
);
   import sti_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // Accept and queue requests
   sti_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_target       (req_target),
      .req_search_count (req_search_count),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // Execute queued transactions
   sti_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_nearest_index (rsp_nearest_index)
   );

endmodule

`default_nettype wire

[verif/sorted_table_interpolator_unit_tb.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolator unit testbench
// Loads breakpoint tables of several sizes, mostly sorted and sometimes
// scrambled. Then it issues interpolation and nearest-index queries under
// random idling and receiver stalls. Each response is checked against an
// in-bench model of the table search and the exact integer interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sorted_table_interpolator_unit_tb;
   import sti_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [1:0]                     mode;
      logic [IDX_W-1:0]               slot;
      logic signed [VALUE_WIDTH-1:0]  px;
      logic signed [VALUE_WIDTH-1:0]  py;
      logic signed [VALUE_WIDTH-1:0]  target;
      logic [CNT_W-1:0]               cnt;
   } request_type;

   typedef struct {
      logic                           ok;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic [IDX_W-1:0]               index;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [IDX_W-1:0] req_slot = '0;
   logic signed [VALUE_WIDTH-1:0] req_point_x = '0;
   logic signed [VALUE_WIDTH-1:0] req_point_y = '0;
   logic signed [VALUE_WIDTH-1:0] req_target = '0;
   logic [CNT_W-1:0] req_search_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_ok;
   logic signed [VALUE_WIDTH-1:0] rsp_sample_value;
   logic [IDX_W-1:0] rsp_nearest_index;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // model state, updated at each accepted transaction
   logic signed [VALUE_WIDTH-1:0] x_tab [TABLE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] y_tab [TABLE_DEPTH];
   logic [CNT_W-1:0] points_cfg = '0;

   // generator view of the table, ahead of the model
   logic signed [VALUE_WIDTH-1:0] gen_x [TABLE_DEPTH];
   bit gen_written [TABLE_DEPTH];

   request_type       pending_requests[$];
   lookup_result_type expected_lookups[$];
   int errors = 0;
   int interp_checked = 0;
   int nearest_checked = 0;
   int sizes_run = 0;
   int quiet_left = 0;
   int req_wait = 0;
   int stall_hold = 0;

   sorted_table_interpolator_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_slot(req_slot),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_target(req_target), .req_search_count(req_search_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok), .rsp_sample_value(rsp_sample_value),
      .rsp_nearest_index(rsp_nearest_index),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and quiet stretches with none
   function automatic int pick_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) quiet_left = $urandom_range(30, 120);
      if (r < 110) return 0;
      if (r < 170) return $urandom_range(1, 3);
      if (r < 194) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned lower_index(int unsigned n, longint t);
      int unsigned first, len, half, mid;
      first = 0;
      len = n;
      while (len > 0) begin
         half = len / 2;
         mid = first + half;
         if (longint'(x_tab[mid]) < t) begin
            first = mid + 1;
            len -= half + 1;
         end else begin
            len = half;
         end
      end
      return first;
   endfunction

   function automatic lookup_result_type predict_lookup(request_type rq);
      lookup_result_type res;
      int unsigned n, r;
      longint t, xl, span, m, diff, yl, dl, dr;
      logic [65:0] prod, quot;
      res = '{ok: 1'b1, value: '0, index: '0};
      t = longint'(rq.target);
      n = (points_cfg > TABLE_DEPTH) ? TABLE_DEPTH : points_cfg;
      if (rq.mode == OP_INTERP) begin
         if (n == 0 || t < longint'(x_tab[0]) || t > longint'(x_tab[n-1])) begin
            res.ok = 1'b0;
            return res;
         end
         r = lower_index(n, t);
         if (r == 0) res.value = y_tab[0];
         else if (r == n) res.value = y_tab[n-1];
         else begin
            xl = longint'(x_tab[r-1]);
            span = longint'(x_tab[r]) - xl;
            if (span <= 0) res.value = y_tab[r];
            else begin
               m = t - xl;
               if (m < 0) m = 0;
               if (m > span) m = span;
               yl = longint'(y_tab[r-1]);
               diff = longint'(y_tab[r]) - yl;
               prod = 66'(diff < 0 ? -diff : diff) * 66'(m);
               quot = prod / 66'(span);
               res.value = VALUE_WIDTH'(diff < 0 ? yl - longint'(quot) : yl + longint'(quot));
            end
         end
      end else begin
         if (rq.cnt < n) n = rq.cnt;
         if (n < 2) return res;
         r = lower_index(n, t);
         if (r == 0) res.index = '0;
         else if (r == n) res.index = IDX_W'(n - 1);
         else begin
            dl = longint'(x_tab[r-1]) - t;
            dr = longint'(x_tab[r]) - t;
            if (dl < 0) dl = -dl;
            if (dr < 0) dr = -dr;
            res.index = IDX_W'(dl <= dr ? r - 1 : r);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   // drive the request channel; hold the payload while stalled
   always @(posedge clock) begin
      request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            rq = pending_requests.pop_front();
            req_mode <= rq.mode;
            req_slot <= rq.slot;
            req_point_x <= rq.px;
            req_point_y <= rq.py;
            req_target <= rq.target;
            req_search_count <= rq.cnt;
            req_valid <= 1'b1;
            req_wait = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the response channel in random runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else begin
         stall_hold = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      request_type rq;
      lookup_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rq = '{req_mode, req_slot, req_point_x, req_point_y, req_target,
                   req_search_count};
            if (rq.mode == OP_WRITE) begin
               x_tab[rq.slot] = rq.px;
               y_tab[rq.slot] = rq.py;
            end else if (rq.mode == OP_INTERP || rq.mode == OP_NEAREST) begin
               expected_lookups.push_back(predict_lookup(rq));
               if (rq.mode == OP_INTERP) interp_checked++;
               else nearest_checked++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("unexpected response, ok", rsp_ok, 0);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
               if (rsp_sample_value !== want.value)
                  report_mismatch("sample_value", rsp_sample_value, want.value);
               if (rsp_nearest_index !== want.index)
                  report_mismatch("nearest_index", rsp_nearest_index, want.index);
            end
         end
      end
   end

   task automatic push_req(logic [1:0] mode, int slot, longint px, longint py,
                           longint target, int cnt);
      request_type rq;
      rq = '{mode, IDX_W'(slot), VALUE_WIDTH'(px), VALUE_WIDTH'(py),
             VALUE_WIDTH'(target), CNT_W'(cnt)};
      if (mode == OP_WRITE) begin
         gen_x[rq.slot] = rq.px;
         gen_written[rq.slot] = 1'b1;
      end
      pending_requests.push_back(rq);
   endtask

   // drain all traffic, let the unit settle, then set the point count
   task automatic set_points(int value);
      wait (pending_requests.size() == 0 && !req_valid && expected_lookups.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      points_cfg = CNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sizes_run++;
   endtask

   function automatic longint rand_value();
      case ($urandom_range(0, 9))
         0: return -64'sd2147483648;
         1: return 64'sd2147483647;
         default: return longint'($signed($urandom()));
      endcase
   endfunction

   // load slots 0..n-1 with non-decreasing x, or scrambled x
   task automatic fill_table(int n, bit scramble);
      longint stride, x;
      int unsigned slack;
      if (n == 0) return;
      stride = 64'd4294967295 / n;
      slack = 32'(64'd4294967295 - (n - 1) * stride);
      x = -64'sd2147483648 + longint'($urandom_range(0, slack));
      for (int i = 0; i < n; i++) begin
         if (scramble) x = longint'($signed($urandom()));
         else if (i > 0) begin
            case ($urandom_range(0, 9))
               0: x = x;
               1, 2, 3: x += $urandom_range(1, 16);
               default: x += longint'($urandom_range(1, 32'(stride)));
            endcase
         end
         push_req(OP_WRITE, i, x, rand_value(), 0, 0);
      end
   endtask

   function automatic longint pick_target(int n);
      int i;
      longint a, b;
      if (n == 0 || $urandom_range(0, 9) == 0) return rand_value();
      i = $urandom_range(0, n - 1);
      a = longint'(gen_x[i]);
      b = (i + 1 < n) ? longint'(gen_x[i+1]) : a;
      case ($urandom_range(0, 7))
         0: return a;
         1: return (a + b) >>> 1;
         2: return longint'(gen_x[0]) - 1;
         3: return longint'(gen_x[n-1]) + 1;
         default: return (b > a) ? a + longint'($urandom_range(0, 32'(b - a))) : a;
      endcase
   endfunction

   // queries with random content and occasional writes and unused modes
   task automatic run_queries(int n, int count);
      int r, cnt;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                            : $urandom_range(0, n + 1);
         if (r < 6)
            push_req(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1), rand_value(),
                     rand_value(), rand_value(), $urandom_range(0, 2047));
         else if (r < 9)
            push_req(MODE_UNUSED, $urandom_range(0, TABLE_DEPTH - 1), rand_value(),
                     rand_value(), rand_value(), $urandom_range(0, 2047));
         else
            push_req(r < 55 ? OP_INTERP : OP_NEAREST, $urandom_range(0, TABLE_DEPTH - 1),
                     rand_value(), rand_value(), pick_target(n), cnt);
      end
   endtask

   initial begin
      int sizes[$];
      int n;
      sizes = '{3, 4, 7, 16, 50, 200, 1024, 2047, 5, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: queries fail or return zero, unused mode dropped
      push_req(OP_INTERP, 0, 0, 0, 0, 0);
      push_req(OP_NEAREST, 0, 0, 0, 5, 2047);
      push_req(MODE_UNUSED, 1023, -1, -1, -1, 2047);
      push_req(OP_WRITE, 0, -5, 7, 0, 0);
      set_points(1);
      push_req(OP_INTERP, 0, 0, 0, -5, 0);
      push_req(OP_INTERP, 0, 0, 0, -4, 0);
      push_req(OP_NEAREST, 0, 0, 0, -4, 2047);

      // coordinate extremes: full span, full negative y swing
      push_req(OP_WRITE, 0, -64'sd2147483648, 64'sd2147483647, 0, 0);
      push_req(OP_WRITE, 1, 64'sd2147483647, -64'sd2147483648, 0, 0);
      push_req(OP_WRITE, 1023, 1, 1, 0, 0);
      set_points(2);
      push_req(OP_INTERP, 0, 0, 0, 0, 0);
      push_req(OP_INTERP, 0, 0, 0, 64'sd2147483647, 0);
      push_req(OP_INTERP, 0, 0, 0, -64'sd2147483648, 0);
      push_req(OP_INTERP, 0, 0, 0, -1, 0);
      push_req(OP_NEAREST, 0, 0, 0, 0, 2);

      // tie on nearest goes left; counts below two give zero
      push_req(OP_WRITE, 0, 0, 100, 0, 0);
      push_req(OP_WRITE, 1, 4, 300, 0, 0);
      push_req(OP_NEAREST, 0, 0, 0, 2, 2);
      push_req(OP_NEAREST, 0, 0, 0, 3, 2);
      push_req(OP_NEAREST, 0, 0, 0, -100, 2);
      push_req(OP_NEAREST, 0, 0, 0, 100, 2);
      push_req(OP_NEAREST, 0, 0, 0, 3, 1);
      push_req(OP_NEAREST, 0, 0, 0, 3, 0);
      push_req(OP_INTERP, 0, 0, 0, 1, 0);

      // random phases over table sizes, oversized count saturates
      foreach (sizes[p]) begin
         n = (sizes[p] > TABLE_DEPTH) ? TABLE_DEPTH : sizes[p];
         set_points(sizes[p]);
         if (sizes[p] <= TABLE_DEPTH)
            fill_table(n, n > 2 && ($urandom_range(0, 3) == 0 || p == 8));
         run_queries(n, n >= 200 ? 100 : 40);
      end

      wait (pending_requests.size() == 0 && !req_valid && expected_lookups.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d interpolations and %0d nearest lookups", interp_checked,
               nearest_checked);
      $display("over %0d point-count settings, sorted and scrambled tables", sizes_run);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d responses outstanding", expected_lookups.size());
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
